FILE: rtl/srrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrd_pkg
// Shared types and constants of the sprite row run-length decoder.
// ----------------------------------------------------------------------------
package srrd_pkg;

    // longest row the decoder builds
    localparam int MAX_LINE = 2048;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 12;
    localparam int COLUMN_W = 11;
    localparam int RUN_W    = 7;
    localparam int BURST_W  = 6;
    localparam int COL_W    = $clog2(MAX_LINE + 1);
    localparam int CMP_W    = (COL_W > LEN_W) ? COL_W : LEN_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COLOR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 12'd320;

    // parser phase
    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_REP  = 2'd2
    } phase_t;

    // controller states
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_BURST  = 2'b10
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic starts_burst;
        logic burst_more;
        logic burst_last;
    } dp_status_t;

endpackage

FILE: rtl/srrd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrd_datapath
// Byte parser, column counter, burst counter and output register.
// ----------------------------------------------------------------------------
module srrd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [srrd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [srrd_pkg::LEN_W-1:0]          cfg_wdata,
    input  logic [srrd_pkg::BYTE_W-1:0]         s_data_byte,
    input  logic                                s_row_start,
    input  srrd_pkg::dp_cmd_t                   cmd,
    output srrd_pkg::dp_status_t                status,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [srrd_pkg::BYTE_W-1:0]         m_pixel,
    output logic [srrd_pkg::COLUMN_W-1:0]       m_column,
    output logic                                m_is_skip,
    output logic                                m_end_of_run,
    output logic                                m_last_of_row
);

    localparam int COL_W = srrd_pkg::COL_W;
    localparam int CMP_W = srrd_pkg::CMP_W;

    // configuration
    logic [srrd_pkg::BYTE_W-1:0] skip_color_reg;
    logic [srrd_pkg::LEN_W-1:0]  line_length_reg;

    // parser state
    srrd_pkg::phase_t            phase_reg, phase_next;
    logic [srrd_pkg::RUN_W-1:0]  run_left_reg, run_left_next;
    logic [COL_W-1:0]            col_reg, col_next;

    // burst state
    logic [srrd_pkg::BURST_W-1:0] burst_cnt_reg, burst_cnt_next;
    logic [srrd_pkg::BYTE_W-1:0]  burst_color_reg, burst_color_next;
    logic                         burst_skip_reg, burst_skip_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [srrd_pkg::BYTE_W-1:0]  out_pixel_reg, out_pixel_next;
    logic [COL_W-1:0]             out_col_reg, out_col_next;
    logic                         out_skip_reg, out_skip_next;
    logic                         out_end_reg, out_end_next;
    logic                         out_last_reg, out_last_next;

    logic [CMP_W-1:0]    len_ext;
    logic [CMP_W-1:0]    max_ext;
    logic [COL_W-1:0]    eff_len;
    srrd_pkg::phase_t    eff_phase;
    logic [COL_W-1:0]    eff_col;
    logic                row_full;
    logic                out_load;

    // effective row length, clipped to the longest row
    assign len_ext = CMP_W'(line_length_reg);
    assign max_ext = CMP_W'(srrd_pkg::MAX_LINE);
    assign eff_len = (len_ext > max_ext) ? COL_W'(max_ext) : COL_W'(len_ext);

    // a row start abandons whatever was pending
    assign eff_phase = s_row_start ? srrd_pkg::PH_CTRL : phase_reg;
    assign eff_col   = s_row_start ? '0 : col_reg;
    assign row_full  = (eff_col >= eff_len);

    // status for the controller
    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.starts_burst = (eff_phase == srrd_pkg::PH_REP) ||
                                 ((eff_phase != srrd_pkg::PH_LIT) &&
                                  s_data_byte[7] && s_data_byte[6]);
    assign status.burst_more   = (burst_cnt_reg != '0) && (col_reg < eff_len);
    assign status.burst_last   = (burst_cnt_reg == srrd_pkg::BURST_W'(1)) ||
                                 ((col_reg + COL_W'(1)) == eff_len);

    // parser and pixel generation
    always_comb begin
        phase_next       = phase_reg;
        run_left_next    = run_left_reg;
        col_next         = col_reg;
        burst_cnt_next   = burst_cnt_reg;
        burst_color_next = burst_color_reg;
        burst_skip_next  = burst_skip_reg;
        out_load         = 1'b0;
        out_pixel_next   = out_pixel_reg;
        out_col_next     = out_col_reg;
        out_skip_next    = out_skip_reg;
        out_end_next     = out_end_reg;
        out_last_next    = out_last_reg;

        if (cmd.take) begin
            col_next = eff_col;
            case (eff_phase)
                srrd_pkg::PH_LIT: begin
                    if (!row_full) begin
                        out_load       = 1'b1;
                        out_pixel_next = s_data_byte;
                        out_col_next   = eff_col;
                        out_skip_next  = 1'b0;
                        out_end_next   = 1'b1;
                        out_last_next  = ((eff_col + COL_W'(1)) == eff_len);
                        col_next       = eff_col + COL_W'(1);
                    end
                    run_left_next = run_left_reg - srrd_pkg::RUN_W'(1);
                    phase_next    = (run_left_reg == srrd_pkg::RUN_W'(1)) ?
                                    srrd_pkg::PH_CTRL : srrd_pkg::PH_LIT;
                end
                srrd_pkg::PH_REP: begin
                    burst_cnt_next   = run_left_reg[srrd_pkg::BURST_W-1:0];
                    burst_color_next = s_data_byte;
                    burst_skip_next  = 1'b0;
                    run_left_next    = '0;
                    phase_next       = srrd_pkg::PH_CTRL;
                end
                default: begin
                    if (!s_data_byte[7]) begin
                        // literal run
                        run_left_next = s_data_byte[srrd_pkg::RUN_W-1:0];
                        phase_next    = (s_data_byte[srrd_pkg::RUN_W-1:0] != '0) ?
                                        srrd_pkg::PH_LIT : srrd_pkg::PH_CTRL;
                    end else if (s_data_byte[6]) begin
                        // skip run
                        burst_cnt_next   = s_data_byte[srrd_pkg::BURST_W-1:0];
                        burst_color_next = skip_color_reg;
                        burst_skip_next  = 1'b1;
                        run_left_next    = '0;
                        phase_next       = srrd_pkg::PH_CTRL;
                    end else begin
                        // repeat run, colour byte follows
                        run_left_next = {1'b0, s_data_byte[srrd_pkg::BURST_W-1:0]};
                        phase_next    = srrd_pkg::PH_REP;
                    end
                end
            endcase
        end else if (cmd.emit) begin
            out_load       = 1'b1;
            out_pixel_next = burst_color_reg;
            out_col_next   = col_reg;
            out_skip_next  = burst_skip_reg;
            out_end_next   = status.burst_last;
            out_last_next  = ((col_reg + COL_W'(1)) == eff_len);
            col_next       = col_reg + COL_W'(1);
            burst_cnt_next = burst_cnt_reg - srrd_pkg::BURST_W'(1);
        end
    end

    // output valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_color_reg  <= '0;
            line_length_reg <= srrd_pkg::LINE_LENGTH_RESET;
            phase_reg       <= srrd_pkg::PH_CTRL;
            run_left_reg    <= '0;
            col_reg         <= '0;
            burst_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    srrd_pkg::REG_SKIP_COLOR:
                        skip_color_reg <= cfg_wdata[srrd_pkg::BYTE_W-1:0];
                    default:
                        line_length_reg <= cfg_wdata;
                endcase
            end
            phase_reg     <= phase_next;
            run_left_reg  <= run_left_next;
            col_reg       <= col_next;
            burst_cnt_reg <= burst_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        burst_color_reg <= burst_color_next;
        burst_skip_reg  <= burst_skip_next;
        out_pixel_reg   <= out_pixel_next;
        out_col_reg     <= out_col_next;
        out_skip_reg    <= out_skip_next;
        out_end_reg     <= out_end_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel       = out_pixel_reg;
    assign m_column      = srrd_pkg::COLUMN_W'(out_col_reg);
    assign m_is_skip     = out_skip_reg;
    assign m_end_of_run  = out_end_reg;
    assign m_last_of_row = out_last_reg;

`ifndef SYNTH
    // a beat is loaded only when the output register can take it
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> status.out_free)
        else $error("output register overwritten");

    // a repeat colour byte is pending only with a six-bit count
    a_rep_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == srrd_pkg::PH_REP) |-> (run_left_reg[srrd_pkg::RUN_W-1] == 1'b0))
        else $error("repeat count out of range");
`endif

endmodule

FILE: rtl/srrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrd_ctrl
// Controller: takes row bytes and sequences repeat and skip bursts.
// ----------------------------------------------------------------------------
module srrd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  srrd_pkg::dp_status_t  status,
    output srrd_pkg::dp_cmd_t     cmd
);

    srrd_pkg::ctrl_state_t state_reg, state_next;

    // byte intake only between bursts and with room at the output
    assign s_ready  = (state_reg == srrd_pkg::ST_ACCEPT) && status.out_free;
    assign cmd.take = s_valid && s_ready;
    assign cmd.emit = (state_reg == srrd_pkg::ST_BURST) && status.burst_more &&
                      status.out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srrd_pkg::ST_ACCEPT: begin
                if (cmd.take && status.starts_burst) begin
                    state_next = srrd_pkg::ST_BURST;
                end
            end
            srrd_pkg::ST_BURST: begin
                if (!status.burst_more) begin
                    state_next = srrd_pkg::ST_ACCEPT;
                end else if (cmd.emit && status.burst_last) begin
                    state_next = srrd_pkg::ST_ACCEPT;
                end
            end
            default: begin
                state_next = srrd_pkg::ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srrd_pkg::ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    // no byte is taken while a burst runs
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srrd_pkg::ST_BURST) |-> !s_ready)
        else $error("byte taken during burst");

    // intake and burst pixels never compete for the output
    a_take_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take && cmd.emit))
        else $error("take and emit together");

    // a burst that ends on a pixel returns to intake
    a_burst_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.burst_last) |=> (state_reg == srrd_pkg::ST_ACCEPT))
        else $error("burst did not end");
`endif

endmodule

FILE: rtl/sprite_row_rle_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_row_rle_decoder
// Run-length decoder for one compressed sprite row, byte in, pixel out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes the row bytes, control and colour bytes interleaved;
//   s_row_start marks the first byte of a row and clears the parser.
//   m_* channel gives one pixel per beat with its column and flags.
//   cfg_* writes skip_color (index 0) and line_length (index 1) while idle.
// A literal pixel is loaded into the output register as its byte is taken.
// Pixels at or past the row length are dropped.
// A literal or control byte is taken whenever no burst runs and the output
//   register has room. A repeat colour byte or skip control byte starts a
//   burst, in which the burst counter drives one pixel a cycle into the output
//   register while it has room; no byte is taken until the burst ends.
// Reset: parser at control byte, column zero, skip_color 0, line_length 320.
// Stall: while m_ready is low and the output register holds a beat, it keeps
//   the beat, no byte is taken and no burst pixel advances.
// ----------------------------------------------------------------------------
module sprite_row_rle_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [srrd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [srrd_pkg::LEN_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [srrd_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                              s_row_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [srrd_pkg::BYTE_W-1:0]       m_pixel,
    output logic [srrd_pkg::COLUMN_W-1:0]     m_column,
    output logic                              m_is_skip,
    output logic                              m_end_of_run,
    output logic                              m_last_of_row
);

    srrd_pkg::dp_cmd_t    cmd;
    srrd_pkg::dp_status_t status;

    srrd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    srrd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_data_byte   (s_data_byte),
        .s_row_start   (s_row_start),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_pixel       (m_pixel),
        .m_column      (m_column),
        .m_is_skip     (m_is_skip),
        .m_end_of_run  (m_end_of_run),
        .m_last_of_row (m_last_of_row)
    );

endmodule
